>>> rtl/core/sai_pkg.sv
// Package for the saturating integer ALU: payload structs, operation codes,
// pipeline stage struct and clamp constants. No dependencies.
package sai_pkg;

   localparam logic [3:0] KIND_ADD32 = 4'd0;
   localparam logic [3:0] KIND_SUB32 = 4'd1;
   localparam logic [3:0] KIND_MUL32 = 4'd2;
   localparam logic [3:0] KIND_DIV32 = 4'd3;
   localparam logic [3:0] KIND_ADD64 = 4'd4;
   localparam logic [3:0] KIND_SUB64 = 4'd5;
   localparam logic [3:0] KIND_MUL64 = 4'd6;
   localparam logic [3:0] KIND_DIV64 = 4'd7;
   localparam logic [3:0] KIND_ADDU  = 4'd8;
   localparam logic [3:0] KIND_SUBU  = 4'd9;
   localparam logic [3:0] KIND_MULU  = 4'd10;

   localparam logic [63:0] S32_TOP    = 64'h0000_0000_7FFF_FFFF;
   localparam logic [63:0] S32_BOTTOM = 64'hFFFF_FFFF_8000_0000;
   localparam logic [63:0] INT32_NMAG = 64'h0000_0000_8000_0000;
   localparam logic [63:0] S64_TOP    = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] S64_BOTTOM = 64'h8000_0000_0000_0000;
   localparam logic [63:0] U32_TOP    = 64'h0000_0000_FFFF_FFFF;

   localparam int unsigned NUM_CELLS = 64;

   typedef enum logic [1:0] {
      MODE_PASS,
      MODE_MUL,
      MODE_DIV
   } mode_type;

   typedef struct packed {
      logic [3:0]         kind;
      logic signed [63:0] operand_a;
      logic signed [63:0] operand_b;
   } req_type;

   typedef struct packed {
      logic signed [63:0] result;
      logic               overflow;
      logic               divide_by_zero;
   } rsp_type;

   // acc: product or partial remainder (or the final result in pass mode)
   // sh:  multiplier bits or dividend bits, quotient shifts in at the bottom
   // mb:  multiplicand or divisor magnitude
   typedef struct packed {
      logic [3:0]  kind;
      mode_type    mode;
      logic        neg;
      logic        big;
      logic        ovf;
      logic        dbz;
      logic [63:0] acc;
      logic [63:0] sh;
      logic [63:0] mb;
   } stage_type;

   function automatic logic [63:0] mag64(input logic [63:0] x);
      return x[63] ? (64'd0 - x) : x;
   endfunction

endpackage

>>> rtl/core/sai_prep.sv
// Operand decode for the saturating ALU: finishes add and subtract outright
// and sets up magnitudes for the multiply/divide cell chain. Uses sai_pkg.
module sai_prep (
   input  sai_pkg::req_type   req,
   output sai_pkg::stage_type stage
);

   logic        [63:0] a;
   logic        [63:0] b;
   logic signed [63:0] sa;
   logic signed [63:0] sb;
   logic        [63:0] ua;
   logic        [63:0] ub;
   logic signed [63:0] s32;
   logic        [63:0] r64;

   assign a  = req.operand_a;
   assign b  = req.operand_b;
   assign sa = {{32{a[31]}}, a[31:0]};
   assign sb = {{32{b[31]}}, b[31:0]};
   assign ua = {32'd0, a[31:0]};
   assign ub = {32'd0, b[31:0]};

   always_comb begin
      stage      = '0;
      stage.kind = req.kind;
      stage.mode = sai_pkg::MODE_PASS;
      s32        = '0;
      r64        = '0;
      unique case (req.kind) inside
         sai_pkg::KIND_ADD32, sai_pkg::KIND_SUB32: begin
            s32 = (req.kind == sai_pkg::KIND_ADD32) ? (sa + sb) : (sa - sb);
            if (s32 > $signed(sai_pkg::S32_TOP)) begin
               stage.ovf = 1'b1;
               stage.acc = sai_pkg::S32_TOP;
            end else if (s32 < $signed(sai_pkg::S32_BOTTOM)) begin
               stage.ovf = 1'b1;
               stage.acc = sai_pkg::S32_BOTTOM;
            end else begin
               stage.acc = s32;
            end
         end
         sai_pkg::KIND_ADD64: begin
            r64 = a + b;
            if (a[63] == b[63] && r64[63] != a[63]) begin
               stage.ovf = 1'b1;
               stage.acc = b[63] ? sai_pkg::S64_BOTTOM : sai_pkg::S64_TOP;
            end else begin
               stage.acc = r64;
            end
         end
         sai_pkg::KIND_SUB64: begin
            r64 = a - b;
            if (a[63] != b[63] && r64[63] != a[63]) begin
               stage.ovf = 1'b1;
               stage.acc = b[63] ? sai_pkg::S64_TOP : sai_pkg::S64_BOTTOM;
            end else begin
               stage.acc = r64;
            end
         end
         sai_pkg::KIND_ADDU: begin
            r64 = ua + ub;
            if (r64 > sai_pkg::U32_TOP) begin
               stage.ovf = 1'b1;
               stage.acc = sai_pkg::U32_TOP;
            end else begin
               stage.acc = r64;
            end
         end
         sai_pkg::KIND_SUBU: begin
            if (ub > ua) begin
               stage.ovf = 1'b1;
            end else begin
               stage.acc = ua - ub;
            end
         end
         sai_pkg::KIND_MUL32: begin
            stage.mode = sai_pkg::MODE_MUL;
            stage.neg  = sa[63] ^ sb[63];
            stage.mb   = sai_pkg::mag64(sa);
            stage.sh   = sai_pkg::mag64(sb);
         end
         sai_pkg::KIND_MUL64: begin
            stage.mode = sai_pkg::MODE_MUL;
            stage.neg  = a[63] ^ b[63];
            stage.mb   = sai_pkg::mag64(a);
            stage.sh   = sai_pkg::mag64(b);
         end
         sai_pkg::KIND_MULU: begin
            stage.mode = sai_pkg::MODE_MUL;
            stage.mb   = ua;
            stage.sh   = ub;
         end
         sai_pkg::KIND_DIV32: begin
            if (b[31:0] == 32'd0) begin
               stage.dbz = 1'b1;
            end else begin
               stage.mode = sai_pkg::MODE_DIV;
               stage.neg  = sa[63] ^ sb[63];
               stage.sh   = sai_pkg::mag64(sa);
               stage.mb   = sai_pkg::mag64(sb);
            end
         end
         sai_pkg::KIND_DIV64: begin
            if (b == 64'd0) begin
               stage.dbz = 1'b1;
            end else begin
               stage.mode = sai_pkg::MODE_DIV;
               stage.neg  = a[63] ^ b[63];
               stage.sh   = sai_pkg::mag64(a);
               stage.mb   = sai_pkg::mag64(b);
            end
         end
         default: begin
            stage.acc = '0;
         end
      endcase
   end

endmodule

>>> rtl/core/sai_cell.sv
// One cell of the multiply/divide chain: a single shift-add or
// shift-subtract step on one operand bit, registered. Uses sai_pkg.
module sai_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               prev_valid,
   input  sai_pkg::stage_type prev_stage,
   output logic               valid_ff,
   output sai_pkg::stage_type stage_ff
);

   sai_pkg::stage_type step_in;
   logic [65:0]        mul_sum;
   logic [64:0]        rem_wide;
   logic [64:0]        rem_diff;

   assign mul_sum  = {1'b0, prev_stage.acc, 1'b0} +
                     {2'b00, (prev_stage.sh[63] ? prev_stage.mb : 64'd0)};
   assign rem_wide = {prev_stage.acc, prev_stage.sh[63]};
   assign rem_diff = rem_wide - {1'b0, prev_stage.mb};

   always_comb begin
      step_in = prev_stage;
      case (prev_stage.mode)
         sai_pkg::MODE_MUL: begin
            // product above 64 bits only grows from here: keep it sticky
            step_in.acc = mul_sum[63:0];
            step_in.big = prev_stage.big | (mul_sum[65:64] != 2'b00);
            step_in.sh  = {prev_stage.sh[62:0], 1'b0};
         end
         sai_pkg::MODE_DIV: begin
            if (rem_wide >= {1'b0, prev_stage.mb}) begin
               step_in.acc = rem_diff[63:0];
               step_in.sh  = {prev_stage.sh[62:0], 1'b1};
            end else begin
               step_in.acc = rem_wide[63:0];
               step_in.sh  = {prev_stage.sh[62:0], 1'b0};
            end
         end
         default: begin
            step_in = prev_stage;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= prev_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stage_ff <= step_in;
      end
   end

endmodule

>>> rtl/core/sai_fin.sv
// Result stage of the saturating ALU: signs the chain's magnitude and clamps
// it to the operation's range, or passes decode results. Uses sai_pkg.
module sai_fin (
   input  sai_pkg::stage_type stage,
   output sai_pkg::rsp_type   rsp
);

   logic [63:0] mag;
   logic [63:0] lim_pos;
   logic [63:0] lim_neg;
   logic [63:0] max_v;
   logic [63:0] min_v;
   logic        clip;

   assign mag = (stage.mode == sai_pkg::MODE_DIV) ? stage.sh : stage.acc;

   always_comb begin
      unique case (stage.kind) inside
         sai_pkg::KIND_MUL32, sai_pkg::KIND_DIV32: begin
            lim_pos = sai_pkg::S32_TOP;
            lim_neg = sai_pkg::INT32_NMAG;
            max_v   = sai_pkg::S32_TOP;
            min_v   = sai_pkg::S32_BOTTOM;
         end
         sai_pkg::KIND_MULU: begin
            lim_pos = sai_pkg::U32_TOP;
            lim_neg = sai_pkg::U32_TOP;
            max_v   = sai_pkg::U32_TOP;
            min_v   = '0;
         end
         default: begin
            lim_pos = sai_pkg::S64_TOP;
            lim_neg = sai_pkg::S64_BOTTOM;
            max_v   = sai_pkg::S64_TOP;
            min_v   = sai_pkg::S64_BOTTOM;
         end
      endcase
   end

   assign clip = stage.big | (stage.neg ? (mag > lim_neg) : (mag > lim_pos));

   always_comb begin
      rsp = '0;
      if (stage.mode == sai_pkg::MODE_PASS) begin
         rsp.result         = stage.acc;
         rsp.overflow       = stage.ovf;
         rsp.divide_by_zero = stage.dbz;
      end else if (clip) begin
         rsp.result   = stage.neg ? min_v : max_v;
         rsp.overflow = 1'b1;
      end else begin
         rsp.result = stage.neg ? (64'd0 - mag) : mag;
      end
   end

endmodule

>>> rtl/core/saturating_integer_alu_top.sv
// Saturating integer ALU top level: decode register, chain of 64 step cells,
// result register. Uses sai_pkg, sai_prep, sai_cell and sai_fin.
//
// Requests arrive on req_valid/req_ready with req_data (kind, operand_a,
// operand_b); results leave on rsp_valid/rsp_ready with rsp_data (result,
// overflow, divide_by_zero), one result per request, in request order.
// Every operation runs through the same pipeline: the decode register, the
// cell chain and the result register, in that order.
// Throughput is one request per cycle for every operation while the output
// is not stalled; multiply and divide take one operand bit per cell across
// the 64-cell chain, and add, subtract and divide by zero are finished in
// the decode stage and ride the chain unchanged.
// When the receiver holds rsp_ready low with a result waiting, the whole
// pipeline freezes and req_ready drops in the same cycle; it resumes as
// soon as the result is taken. Reset clears all valid bits; no request is
// lost or repeated across a stall.
module saturating_integer_alu_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  sai_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sai_pkg::rsp_type rsp_data
);

   localparam int unsigned N = sai_pkg::NUM_CELLS;

   logic               advance;
   sai_pkg::stage_type prep_stage;
   logic               prep_valid_ff;
   sai_pkg::stage_type prep_stage_ff;
   logic               cell_valid [N];
   sai_pkg::stage_type cell_stage [N];
   sai_pkg::rsp_type   fin_rsp;
   logic               rsp_valid_ff;
   sai_pkg::rsp_type   rsp_data_ff;

   // freeze everything while a finished result is held
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   sai_prep u_prep (
      .req   (req_data),
      .stage (prep_stage)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_valid_ff <= 1'b0;
      end else if (advance) begin
         prep_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prep_stage_ff <= prep_stage;
      end
   end

   for (genvar i = 0; i < N; i++) begin : g_cell
      if (i == 0) begin : g_first
         sai_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .advance    (advance),
            .prev_valid (prep_valid_ff),
            .prev_stage (prep_stage_ff),
            .valid_ff   (cell_valid[i]),
            .stage_ff   (cell_stage[i])
         );
      end else begin : g_rest
         sai_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .advance    (advance),
            .prev_valid (cell_valid[i-1]),
            .prev_stage (cell_stage[i-1]),
            .valid_ff   (cell_valid[i]),
            .stage_ff   (cell_stage[i])
         );
      end
   end

   sai_fin u_fin (
      .stage (cell_stage[N-1]),
      .rsp   (fin_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= cell_valid[N-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= fin_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_dbz_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.divide_by_zero |->
         rsp_data_ff.result == 64'd0 && !rsp_data_ff.overflow)
      else $error("divide by zero result not clean");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> prep_valid_ff)
      else $error("accepted request missing from decode stage");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(cell_valid[N-1]) && $stable(prep_valid_ff))
      else $error("pipeline moved during stall");

   a_last_to_out: assert property (@(posedge clock) disable iff (reset)
      advance && cell_valid[N-1] |=> rsp_valid_ff)
      else $error("result dropped at output register");

endmodule

>>> tb/tb.sv
// Testbench for saturating_integer_alu_top: random and directed requests with
// an in-bench predictor and an in-order scoreboard. Depends on sai_pkg and saturating_integer_alu_top.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY = 70;

   class alu_scoreboard;
      sai_pkg::rsp_type pending[$];
      int               errors;
      int               checked;

      function sai_pkg::rsp_type predict(sai_pkg::req_type q);
         sai_pkg::rsp_type r;
         logic [63:0]      a, b, s, ma, mb, lim;
         longint           sa, sb, t;
         longint unsigned  ua, ub, ut;
         logic             neg;
         a = q.operand_a;
         b = q.operand_b;
         sa = longint'($signed(a[31:0]));
         sb = longint'($signed(b[31:0]));
         ua = {32'd0, a[31:0]};
         ub = {32'd0, b[31:0]};
         r = '0;
         case (q.kind) inside
            sai_pkg::KIND_ADD32, sai_pkg::KIND_SUB32,
            sai_pkg::KIND_MUL32, sai_pkg::KIND_DIV32: begin
               if (q.kind == sai_pkg::KIND_DIV32 && sb == 0) begin
                  r.divide_by_zero = 1'b1;
               end else begin
                  case (q.kind)
                     sai_pkg::KIND_ADD32: t = sa + sb;
                     sai_pkg::KIND_SUB32: t = sa - sb;
                     sai_pkg::KIND_MUL32: t = sa * sb;
                     default:             t = sa / sb;
                  endcase
                  if (t > longint'(sai_pkg::S32_TOP)) begin
                     r.overflow = 1'b1;
                     t = longint'(sai_pkg::S32_TOP);
                  end else if (t < longint'(sai_pkg::S32_BOTTOM)) begin
                     r.overflow = 1'b1;
                     t = longint'(sai_pkg::S32_BOTTOM);
                  end
                  r.result = t;
               end
            end
            sai_pkg::KIND_ADD64: begin
               s = a + b;
               if (((a ^ s) & (b ^ s)) >> 63) begin
                  r.overflow = 1'b1;
                  r.result = b[63] ? sai_pkg::S64_BOTTOM : sai_pkg::S64_TOP;
               end else r.result = s;
            end
            sai_pkg::KIND_SUB64: begin
               s = a - b;
               if (((a ^ b) & (a ^ s)) >> 63) begin
                  r.overflow = 1'b1;
                  r.result = b[63] ? sai_pkg::S64_TOP : sai_pkg::S64_BOTTOM;
               end else r.result = s;
            end
            sai_pkg::KIND_MUL64: begin
               ma = a[63] ? -a : a;
               mb = b[63] ? -b : b;
               neg = a[63] ^ b[63];
               lim = neg ? sai_pkg::S64_BOTTOM : sai_pkg::S64_TOP;
               if (ma != 0 && mb != 0 && mb > lim / ma) begin
                  r.overflow = 1'b1;
                  r.result = neg ? sai_pkg::S64_BOTTOM : sai_pkg::S64_TOP;
               end else begin
                  s = ma * mb;
                  r.result = neg ? -s : s;
               end
            end
            sai_pkg::KIND_DIV64: begin
               if (b == 0) r.divide_by_zero = 1'b1;
               else if (a == sai_pkg::S64_BOTTOM && b == '1) begin
                  r.overflow = 1'b1;
                  r.result = sai_pkg::S64_TOP;
               end else r.result = $signed(a) / $signed(b);
            end
            sai_pkg::KIND_ADDU: begin
               ut = ua + ub;
               if (ut > sai_pkg::U32_TOP) begin
                  r.overflow = 1'b1;
                  ut = sai_pkg::U32_TOP;
               end
               r.result = ut;
            end
            sai_pkg::KIND_SUBU: begin
               if (ub > ua) r.overflow = 1'b1;
               else r.result = ua - ub;
            end
            sai_pkg::KIND_MULU: begin
               ut = ua * ub;
               if (ut > sai_pkg::U32_TOP) begin
                  r.overflow = 1'b1;
                  ut = sai_pkg::U32_TOP;
               end
               r.result = ut;
            end
            default: ;
         endcase
         return r;
      endfunction

      function void note_request(sai_pkg::req_type q);
         pending.push_back(predict(q));
      endfunction

      function void check_result(sai_pkg::rsp_type got);
         sai_pkg::rsp_type want;
         if (pending.size() == 0) begin
            $error("result with none expected: %h", got);
            errors++;
            return;
         end
         want = pending.pop_front();
         checked++;
         if (got.result !== want.result) begin
            $error("result: expected %h actual %h", want.result, got.result);
            errors++;
         end
         if (got.overflow !== want.overflow) begin
            $error("overflow: expected %b actual %b", want.overflow, got.overflow);
            errors++;
         end
         if (got.divide_by_zero !== want.divide_by_zero) begin
            $error("divide_by_zero: expected %b actual %b",
                   want.divide_by_zero, got.divide_by_zero);
            errors++;
         end
      endfunction
   endclass

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   sai_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   sai_pkg::rsp_type rsp_data;

   alu_scoreboard board = new();
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   bit hold_off = 1'b0;
   int sent = 0;

   saturating_integer_alu_top dut (.*);

   always #6 clock = ~clock;

   // receiver: random stalls, long hold-off on request
   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else begin
         if (rsp_valid && rsp_ready) board.check_result(rsp_data);
         rsp_ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic send(sai_pkg::req_type q);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= q;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_request(q);
      sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
   endtask

   function automatic logic [63:0] rand_operand();
      case ($urandom_range(7))
         0: return sai_pkg::S64_BOTTOM;
         1: return sai_pkg::S64_TOP;
         2: return {$urandom, $urandom};
         3: return 64'($signed($urandom_range(8) - 4));
         4: return {{32{1'b0}}, $urandom};
         5: return 64'($signed($urandom));
         6: return {$urandom, $urandom} >> $urandom_range(63);
         default: return sai_pkg::S32_BOTTOM ^
                         (64'($urandom_range(1)) << $urandom_range(63));
      endcase
   endfunction

   task automatic send_random(int count);
      sai_pkg::req_type q;
      repeat (count) begin
         q.kind = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 11))
                                            : 4'($urandom_range(10));
         q.operand_a = rand_operand();
         q.operand_b = rand_operand();
         send(q);
      end
   endtask

   initial begin
      logic [63:0]      edge_vals[6];
      sai_pkg::req_type q;
      int               waited;
      edge_vals = '{sai_pkg::S64_BOTTOM, sai_pkg::S64_TOP, 64'd0, '1,
                    sai_pkg::S32_BOTTOM, sai_pkg::S32_TOP};
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: every operation on extremes, then the special cases
      for (int k = 0; k <= 10; k++) begin
         q.kind = 4'(k);
         q.operand_a = edge_vals[$urandom_range(5)];
         q.operand_b = edge_vals[$urandom_range(5)];
         send(q);
      end
      send('{sai_pkg::KIND_DIV32, 64'h5, 64'h0});
      send('{sai_pkg::KIND_DIV64, 64'h5, 64'h0});
      send('{sai_pkg::KIND_DIV32, sai_pkg::S32_BOTTOM, '1});
      send('{sai_pkg::KIND_DIV64, sai_pkg::S64_BOTTOM, '1});
      send('{sai_pkg::KIND_SUBU, 64'h1, 64'h2});
      send('{sai_pkg::KIND_DIV64, -64'sd7, 64'sd2});
      send('{sai_pkg::KIND_MUL64, sai_pkg::S64_BOTTOM, 64'h1});
      send('{4'd15, '1, '1});
      send('{4'd11, 64'h1, 64'h1});
      drain();

      // hold off receiver while requests keep coming
      hold_off = 1'b1;
      fork
         send_random(120);
         begin
            repeat (300) @(posedge clock);
            hold_off = 1'b0;
         end
      join
      drain();

      send_idle_pct = 8;
      recv_idle_pct = 73;
      send_random(300);
      drain();
      send_idle_pct = 73;
      recv_idle_pct = 8;
      send_random(300);
      drain();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_random(300);
      drain();

      waited = 0;
      while (waited < LATENCY) begin
         @(posedge clock);
         waited++;
      end
      $display("Sent %0d requests over all eleven operations and unused codes;", sent);
      $display("checked %0d results with stalls, long hold-off and full drains.",
               board.checked);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      #5ms;
      $display("[FAIL] regression broken");
      $finish;
   end
endmodule

>>> saturating_integer_alu_top.f
rtl/core/sai_pkg.sv
rtl/core/sai_prep.sv
rtl/core/sai_cell.sv
rtl/core/sai_fin.sv
rtl/core/saturating_integer_alu_top.sv
tb/tb.sv
